FILE: rtl/smallest_prime_factor_sieve_defines.svh
// ----------------------------------------------------------------------------
// Smallest prime factor sieve: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_PRIME_FACTOR_SIEVE_DEFINES_SVH
`define SMALLEST_PRIME_FACTOR_SIEVE_DEFINES_SVH

// Same-cycle implication
`define SPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// Smallest prime factor sieve: package
// Field widths, defaults and the controller state type.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned MAX_NUMBER_DEFAULT = 65535;
  localparam int unsigned QUERY_W            = 16;
  localparam int unsigned LIMIT_W            = 16;
  localparam int unsigned FACTOR_W           = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_P_SQ,
    ST_P_TEST,
    ST_P_CHECK,
    ST_M_READ,
    ST_M_WRITE,
    ST_Q_READ
  } state_t;

endpackage

FILE: rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/smallest_prime_factor_sieve.sv
// ----------------------------------------------------------------------------
// Smallest prime factor sieve
// A query returns the smallest prime factor of a number up to the configured
// limit (0 for primes, 0 and 1); a query above the limit is flagged out of
// range with a zero factor. The first query after reset or after a limit
// write raises busy while the table is rebuilt: a clearing pass over every
// entry up to the effective limit, then the sieve, which squares, tests and
// checks each candidate p with p*p <= limit, reads and writes each multiple
// of each prime found, then tests the final candidate and reads the pending
// query, all bound by the single table port pair. Once built, a query is
// taken every cycle and its result strobes on the following cycle; the
// result of the query that started a build strobes in the first cycle in
// which busy is low again. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve #(
  parameter int unsigned MAX_NUMBER = spf_pkg::MAX_NUMBER_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [spf_pkg::QUERY_W-1:0]  in_query_number,
  output logic                         out_strobe,
  output logic [spf_pkg::FACTOR_W-1:0] out_least_factor,
  output logic                         out_out_of_range,
  input  logic                         cfg_wr_en,
  input  logic [spf_pkg::LIMIT_W-1:0]  cfg_sieve_limit
);

  localparam int unsigned TABLE_MAX   = (MAX_NUMBER < 65535) ? MAX_NUMBER : 65535;
  localparam int unsigned TABLE_DEPTH = TABLE_MAX + 1;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned P_W         = (ADDR_W + 1) / 2 + 1;
  localparam int unsigned SQ_W        = 2 * P_W;

  spf_pkg::state_t state_r, state_nxt;

  logic [spf_pkg::LIMIT_W-1:0] limit_r;
  logic                        built_r, built_nxt;
  logic [spf_pkg::QUERY_W-1:0] query_r, query_nxt;
  logic [ADDR_W-1:0]           ptr_r, ptr_nxt;
  logic [P_W-1:0]              p_r, p_nxt;
  logic [SQ_W-1:0]             sq_r, sq_nxt;
  logic [ADDR_W:0]             m_r, m_nxt;
  logic                        strobe_r, strobe_nxt;
  logic                        oor_r, oor_nxt;

  logic [31:0]                 lim_ext;
  logic [ADDR_W-1:0]           eff_lim;
  logic                        accept;
  logic                        in_oor;
  logic                        sq_over;
  logic                        m_over;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [spf_pkg::FACTOR_W-1:0] wr_data;
  logic [ADDR_W-1:0]           rd_addr;
  logic [spf_pkg::FACTOR_W-1:0] rd_data;

  assign lim_ext = (32'(limit_r) > 32'(TABLE_MAX)) ? 32'(TABLE_MAX) : 32'(limit_r);
  assign eff_lim = lim_ext[ADDR_W-1:0];
  assign accept  = start && !busy;
  assign in_oor  = 32'(in_query_number) > 32'(eff_lim);
  assign sq_over = 32'(sq_r) > 32'(eff_lim);
  assign m_over  = 32'(m_r) > 32'(eff_lim);

  spf_ram #(
    .WIDTH (spf_pkg::FACTOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spf_pkg::ST_IDLE: begin
        if (accept && !built_r) begin
          state_nxt = spf_pkg::ST_CLEAR;
        end
      end
      spf_pkg::ST_CLEAR: begin
        if (ptr_r == eff_lim) begin
          state_nxt = spf_pkg::ST_P_SQ;
        end
      end
      spf_pkg::ST_P_SQ: begin
        state_nxt = spf_pkg::ST_P_TEST;
      end
      spf_pkg::ST_P_TEST: begin
        state_nxt = sq_over ? spf_pkg::ST_Q_READ : spf_pkg::ST_P_CHECK;
      end
      spf_pkg::ST_P_CHECK: begin
        state_nxt = (rd_data != '0) ? spf_pkg::ST_P_SQ : spf_pkg::ST_M_READ;
      end
      spf_pkg::ST_M_READ: begin
        state_nxt = m_over ? spf_pkg::ST_P_SQ : spf_pkg::ST_M_WRITE;
      end
      spf_pkg::ST_M_WRITE: begin
        state_nxt = spf_pkg::ST_M_READ;
      end
      spf_pkg::ST_Q_READ: begin
        state_nxt = spf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spf_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and table access
  always_comb begin
    built_nxt  = built_r;
    query_nxt  = query_r;
    ptr_nxt    = ptr_r;
    p_nxt      = p_r;
    sq_nxt     = sq_r;
    m_nxt      = m_r;
    strobe_nxt = 1'b0;
    oor_nxt    = oor_r;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    wr_data    = '0;
    rd_addr    = in_query_number[ADDR_W-1:0];
    unique case (state_r)
      spf_pkg::ST_IDLE: begin
        if (accept) begin
          query_nxt = in_query_number;
          if (built_r) begin
            strobe_nxt = 1'b1;
            oor_nxt    = in_oor;
          end else begin
            ptr_nxt = '0;
          end
        end
      end
      spf_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        ptr_nxt = ptr_r + 1'b1;
        p_nxt   = P_W'(2);
      end
      spf_pkg::ST_P_SQ: begin
        sq_nxt = SQ_W'(p_r) * SQ_W'(p_r);
      end
      spf_pkg::ST_P_TEST: begin
        rd_addr = ADDR_W'(p_r);
        m_nxt   = (ADDR_W + 1)'(sq_r);
      end
      spf_pkg::ST_P_CHECK: begin
        if (rd_data != '0) begin
          p_nxt = p_r + 1'b1;
        end
      end
      spf_pkg::ST_M_READ: begin
        rd_addr = m_r[ADDR_W-1:0];
        if (m_over) begin
          p_nxt = p_r + 1'b1;
        end
      end
      spf_pkg::ST_M_WRITE: begin
        wr_addr = m_r[ADDR_W-1:0];
        wr_data = spf_pkg::FACTOR_W'(p_r);
        wr_en   = (rd_data == '0);
        m_nxt   = m_r + (ADDR_W + 1)'(p_r);
      end
      spf_pkg::ST_Q_READ: begin
        rd_addr    = query_r[ADDR_W-1:0];
        built_nxt  = 1'b1;
        strobe_nxt = 1'b1;
        oor_nxt    = 32'(query_r) > 32'(eff_lim);
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= spf_pkg::ST_IDLE;
      limit_r  <= spf_pkg::LIMIT_RESET;
      built_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_sieve_limit;
        built_r <= 1'b0;
      end else begin
        built_r <= built_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    ptr_r   <= ptr_nxt;
    p_r     <= p_nxt;
    sq_r    <= sq_nxt;
    m_r     <= m_nxt;
    oor_r   <= oor_nxt;
  end

  assign busy             = (state_r != spf_pkg::ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_out_of_range = oor_r;
  assign out_least_factor = oor_r ? '0 : rd_data;

endmodule

FILE: rtl/spf_checker.sv
// ----------------------------------------------------------------------------
// Smallest prime factor sieve: port checker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "smallest_prime_factor_sieve_defines.svh"

module spf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic [spf_pkg::FACTOR_W-1:0] out_least_factor,
  input logic                         out_out_of_range
);

  `SPF_ASSERT_SAME(a_oor_zero, out_strobe && out_out_of_range, out_least_factor == '0, "out of range result carries a factor")
  `SPF_ASSERT_SAME(a_no_one, out_strobe, out_least_factor != spf_pkg::FACTOR_W'(1), "factor of one reported")
  `SPF_ASSERT_SAME(a_even_two, out_strobe && !out_least_factor[0], (out_least_factor == '0) || (out_least_factor == spf_pkg::FACTOR_W'(2)), "even factor other than two")
  `SPF_ASSERT_NEXT(a_strobe_cause, !(start && !busy) && !busy, !out_strobe, "result strobe without a transaction")

endmodule

bind smallest_prime_factor_sieve spf_checker u_spf_checker (.*);
